@@ rtl/core/clock_power_register_block_defines.svh @@
// Assertion macros for the clock and power register block.
`ifndef CLOCK_POWER_REGISTER_BLOCK_DEFINES_SVH
`define CLOCK_POWER_REGISTER_BLOCK_DEFINES_SVH

`ifndef SYNTHESIS

`define CPR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cpr: same-cycle check failed");

`define CPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cpr: next-cycle check failed");

`else

`define CPR_ASSERT_NOW(label, ante, cons)

`define CPR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/cpr_pkg.sv @@
`default_nettype none

package cpr_pkg;

   localparam int NUM_WORDS   = 64;
   localparam int WORD_W      = 32;
   localparam int ADDR_W      = 8;
   localparam int SIZE_W      = 4;
   localparam int REQ_TYPE_W  = 2;
   localparam int WIDX_W      = 6;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [WIDX_W-1:0] widx_type;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_READ       = 2'd0,
      REQ_WRITE      = 2'd1,
      REQ_SOFT_RESET = 2'd2,
      REQ_NONE       = 2'd3
   } req_kind_type;

   localparam logic [SIZE_W-1:0] SIZE_WORD = 4'd4;

   // word indices of the byte offsets
   localparam widx_type IDX_R10   = widx_type'(8'h10 >> 2);
   localparam widx_type IDX_R14   = widx_type'(8'h14 >> 2);
   localparam widx_type IDX_R20   = widx_type'(8'h20 >> 2);
   localparam widx_type IDX_R24   = widx_type'(8'h24 >> 2);
   localparam widx_type IDX_R2C   = widx_type'(8'h2C >> 2);
   localparam widx_type IDX_PROT  = widx_type'(8'h34 >> 2);
   localparam widx_type IDX_KEY   = widx_type'(8'h38 >> 2);
   localparam widx_type IDX_R3C   = widx_type'(8'h3C >> 2);
   localparam widx_type IDX_R40   = widx_type'(8'h40 >> 2);
   localparam widx_type IDX_R44   = widx_type'(8'h44 >> 2);
   localparam widx_type IDX_R48   = widx_type'(8'h48 >> 2);
   localparam widx_type IDX_R50   = widx_type'(8'h50 >> 2);
   localparam widx_type IDX_R54   = widx_type'(8'h54 >> 2);
   localparam widx_type IDX_I2S   = widx_type'(8'h60 >> 2);
   localparam widx_type IDX_R64   = widx_type'(8'h64 >> 2);
   localparam widx_type IDX_R68   = widx_type'(8'h68 >> 2);
   localparam widx_type IDX_R74   = widx_type'(8'h74 >> 2);
   localparam widx_type IDX_R7C   = widx_type'(8'h7C >> 2);
   localparam widx_type IDX_PCM   = widx_type'(8'h84 >> 2);
   localparam widx_type IDX_RA4   = widx_type'(8'hA4 >> 2);
   localparam widx_type IDX_INTR  = widx_type'(8'hB0 >> 2);
   localparam widx_type IDX_INTRE = widx_type'(8'hB4 >> 2);
   localparam widx_type IDX_RD0   = widx_type'(8'hD0 >> 2);
   localparam widx_type IDX_CPCSR = widx_type'(8'hD4 >> 2);
   localparam widx_type IDX_ERNG  = widx_type'(8'hD8 >> 2);
   localparam widx_type IDX_RNG   = widx_type'(8'hDC >> 2);
   localparam widx_type IDX_RE8   = widx_type'(8'hE8 >> 2);

   localparam word_type KEY_UNLOCK   = 32'h0000_5A5A;
   localparam word_type KEY_RESET    = 32'h0000_A5A5;
   localparam word_type RNG_FILL     = 32'h000F_FFFF;
   localparam word_type CPCSR_READY  = word_type'(32'h1F << 27);

   function automatic word_type reset_value(widx_type idx);
      word_type v;
      v = '0;
      unique case (idx)
         IDX_R2C:  v = 32'h4000_0000;
         IDX_RD0:  v = 32'h0000_0001;
         IDX_R3C:  v = 32'h4099_19B8;
         IDX_KEY:  v = KEY_RESET;
         IDX_R40:  v = 32'h0200_0096;
         IDX_R44:  v = 32'h00FF_0080;
         IDX_R48:  v = 32'h8D00_0000;
         IDX_R10:  v = 32'hA700_0501;
         IDX_R14:  v = 32'hA700_0081;
         IDX_R20:  v = 32'h07FF_FF10;
         IDX_R24:  v = 32'h0080_1500;
         default:  v = '0;
      endcase
      return v;
   endfunction

   // masks busy/stable bits; I2S and PCM dividers swap bits 31 and 30
   function automatic word_type write_filter(widx_type idx, word_type d);
      word_type v;
      v = d;
      unique case (idx) inside
         IDX_R2C:                    v = d & ~32'h1100_0000;
         IDX_R50, IDX_R54, IDX_R68,
         IDX_R74, IDX_R7C, IDX_RA4:  v = d & ~32'h1000_0000;
         IDX_I2S, IDX_PCM:           v = {d[30], d[31], d[29:0]};
         IDX_R64:                    v = d & ~32'h0800_0000;
         IDX_RE8:                    v = d & ~32'h6000_0000;
         IDX_R48:                    v = d & ~32'h8000_0000;
         IDX_R10:                    v = d & ~32'h0000_8400;
         IDX_R14:                    v = d & ~32'h0000_0002;
         default:                    v = d;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/cpr_req_if.sv @@
`default_nettype none

interface cpr_req_if import cpr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [ADDR_W-1:0]     byte_address;
   logic [WORD_W-1:0]     write_data;
   logic [SIZE_W-1:0]     access_size;

   modport source (output valid, req_type, byte_address, write_data, access_size,
                   input  ready);
   modport sink   (input  valid, req_type, byte_address, write_data, access_size,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/cpr_rsp_if.sv @@
`default_nettype none

interface cpr_rsp_if import cpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_data;
   logic              access_taken;

   modport source (output valid, read_data, access_taken, input ready);
   modport sink   (input  valid, read_data, access_taken, output ready);
endinterface

`default_nettype wire

@@ rtl/core/clock_power_register_block.sv @@
// Clock and power manager register file, 64 words of 32 bits.
// req_port carries one bus word per access: a read, a write or a soft-reset
// event. Only 4-byte, word-aligned reads and writes are taken; other reads and
// writes change nothing. Untaken requests return zero with access_taken low.
// rsp_port returns exactly one word per request, in order: read data for a
// taken read, zero otherwise.
// A request is captured in the input register and then moves into the response
// register. The register file is read as the request is captured and updated
// when the request moves into the response register, so one request a cycle is
// taken while rsp_port keeps up. If rsp_port stalls, the held request waits in
// the input register and req_port.ready drops until the response is taken.
// Reset loads the full reset table, protected word included. A soft-reset
// request loads the table but keeps the protected word. Table words are
// tracked by per-word valid bits, so no clearing pass is needed.
`default_nettype none
`include "clock_power_register_block_defines.svh"

module clock_power_register_block
   import cpr_pkg::*;
#(
   parameter int NUM_WORDS = cpr_pkg::NUM_WORDS
) (
   input  wire        clock,
   input  wire        reset,
   cpr_req_if.sink    req_port,
   cpr_rsp_if.source  rsp_port
);

   localparam int IDX_W = $clog2(NUM_WORDS);

   logic                  s1_valid_ff;
   logic [REQ_TYPE_W-1:0] s1_type_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   word_type              s1_data_ff;
   logic [SIZE_W-1:0]     s1_size_ff;
   word_type              s1_mem_ff;

   word_type              word_mem_ff [NUM_WORDS];
   logic [NUM_WORDS-1:0]  valid_ff, valid_in;

   word_type key_ff,   key_in;
   word_type prot_ff,  prot_in;
   word_type cpcsr_ff, cpcsr_in;
   word_type erng_ff,  erng_in;
   word_type rng_ff,   rng_in;

   logic     rsp_valid_ff;
   word_type rsp_read_data_ff, rsp_read_data_in;
   logic     rsp_taken_ff, rsp_taken_in;

   logic             req_fire, s1_adv;
   logic [IDX_W-1:0] req_idx, s1_idx;
   widx_type         s1_widx;
   logic             s1_taken, s1_rd, s1_wr, s1_srst;
   word_type         mem_word, cur_word, rd_value, wr_value;
   logic             mem_we;

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_fire = req_port.valid && req_port.ready;
   assign req_port.ready = !s1_valid_ff || s1_adv;

   assign req_idx = req_port.byte_address[2 +: IDX_W];
   assign s1_idx  = s1_addr_ff[2 +: IDX_W];
   assign s1_widx = widx_type'(s1_idx);

   assign s1_taken = (s1_type_ff == REQ_READ || s1_type_ff == REQ_WRITE)
                     && s1_size_ff == SIZE_WORD && s1_addr_ff[1:0] == 2'b00;
   assign s1_rd    = s1_taken && s1_type_ff == REQ_READ;
   assign s1_wr    = s1_taken && s1_type_ff == REQ_WRITE;
   assign s1_srst  = s1_type_ff == REQ_SOFT_RESET;

   assign mem_word = valid_ff[s1_idx] ? s1_mem_ff : reset_value(s1_widx);
   assign wr_value = write_filter(s1_widx, s1_data_ff);

   always_comb begin
      unique case (s1_widx)
         IDX_CPCSR: cur_word = cpcsr_ff;
         IDX_ERNG:  cur_word = erng_ff;
         IDX_RNG:   cur_word = rng_ff;
         IDX_KEY:   cur_word = key_ff;
         IDX_PROT:  cur_word = prot_ff;
         default:   cur_word = mem_word;
      endcase
   end

   always_comb begin
      key_in   = key_ff;
      prot_in  = prot_ff;
      cpcsr_in = cpcsr_ff;
      erng_in  = erng_ff;
      rng_in   = rng_ff;
      valid_in = valid_ff;
      mem_we   = 1'b0;
      rd_value = cur_word;
      if (s1_srst) begin
         // protected word survives
         key_in   = KEY_RESET;
         cpcsr_in = '0;
         erng_in  = '0;
         rng_in   = '0;
         valid_in = '0;
      end else if (s1_rd) begin
         if (s1_widx == IDX_CPCSR) begin
            cpcsr_in = CPCSR_READY;
            rd_value = CPCSR_READY;
         end else if (s1_widx == IDX_RNG && erng_ff[0]) begin
            rng_in   = RNG_FILL;
            erng_in  = {1'b0, erng_ff[WORD_W-2:0]};
            rd_value = RNG_FILL;
         end
      end else if (s1_wr) begin
         unique case (s1_widx) inside
            IDX_CPCSR, IDX_INTR, IDX_INTRE: ;
            IDX_PROT: begin
               if (key_ff == KEY_UNLOCK) begin
                  prot_in = s1_data_ff;
               end
            end
            IDX_KEY:  key_in  = wr_value;
            IDX_ERNG: erng_in = wr_value;
            IDX_RNG:  rng_in  = wr_value;
            default: begin
               mem_we           = 1'b1;
               valid_in[s1_idx] = 1'b1;
            end
         endcase
      end
      rsp_read_data_in = s1_rd ? rd_value : '0;
      rsp_taken_in     = s1_taken;
   end

   // register file: one write, one registered read with write-through
   always_ff @(posedge clock) begin
      if (s1_adv && mem_we) begin
         word_mem_ff[s1_idx] <= wr_value;
      end
      if (req_fire) begin
         if (s1_adv && mem_we && s1_idx == req_idx) begin
            s1_mem_ff <= wr_value;
         end else begin
            s1_mem_ff <= word_mem_ff[req_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff <= req_port.req_type;
         s1_addr_ff <= req_port.byte_address;
         s1_data_ff <= req_port.write_data;
         s1_size_ff <= req_port.access_size;
      end
      if (s1_adv) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_taken_ff     <= rsp_taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         key_ff       <= KEY_RESET;
         prot_ff      <= '0;
         cpcsr_ff     <= '0;
         erng_ff      <= '0;
         rng_ff       <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            valid_ff     <= valid_in;
            key_ff       <= key_in;
            prot_ff      <= prot_in;
            cpcsr_ff     <= cpcsr_in;
            erng_ff      <= erng_in;
            rng_ff       <= rng_in;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.read_data    = rsp_read_data_ff;
   assign rsp_port.access_taken = rsp_taken_ff;

   `CPR_ASSERT_NOW(a_reject_zero, rsp_valid_ff && !rsp_taken_ff, rsp_read_data_ff == '0)
   `CPR_ASSERT_NOW(a_prot_locked, key_ff != KEY_UNLOCK, prot_in == prot_ff)
   `CPR_ASSERT_NEXT(a_soft_reset, s1_adv && s1_srst, key_ff == KEY_RESET && valid_ff == '0)
   `CPR_ASSERT_NOW(a_stall_hold, rsp_valid_ff && !rsp_port.ready, !s1_adv)

endmodule

`default_nettype wire
